@@ rtl/mfma_pkg.sv @@
// Shared widths, constants and types for the field magnitude anomaly block.
`default_nettype none
package mfma_pkg;

  localparam int GAIN_W   = 24;
  localparam int WEIGHT_W = 16;
  localparam int FIELD_W  = 28;
  localparam int FRAC_W   = 16;
  localparam int AVG_W    = FIELD_W + FRAC_W;
  localparam int PROD_W   = 2 * GAIN_W;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 3;

  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 24'd873813;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd655;
  localparam logic [FIELD_W-1:0]  FIELD_MAX    = {FIELD_W{1'b1}};

  localparam logic REG_GAIN   = 1'b0;
  localparam logic REG_WEIGHT = 1'b1;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SUM  = 7'b0000010,
    ST_ROOT = 7'b0000100,
    ST_GAIN = 7'b0001000,
    ST_SAT  = 7'b0010000,
    ST_EMA  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

endpackage
`default_nettype wire

@@ rtl/magnetic_field_magnitude_anomaly.sv @@
// Top level: axis lanes, sum merge, square root, gain scaling and running average.
`default_nettype none
// Each reading is squared in three parallel axis lanes, merged into one sum, and
// passed through a square-root unit that yields one root bit per cycle; that unit
// sets the rate. The next item can be taken only after the previous result has
// gone into the output register, so readings never overlap. While a result is
// held in the output register under stall, the next result waits in the last
// stage and the input stays stalled. The running average starts unseeded after
// reset; the first reading seeds it. Registers sit at byte 0 (gain, Q8.16) and
// byte 4 (average weight, Q0.16); paddr[2] selects.
module magnetic_field_magnitude_anomaly import mfma_pkg::*; #(
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [APB_AW-1:0]   paddr,
  input  wire logic [APB_DW-1:0]   pwdata,
  output logic      [APB_DW-1:0]   prdata,
  output logic                     pready,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [23:0]         in_x_sample,
  input  wire logic [23:0]         in_y_sample,
  input  wire logic [23:0]         in_z_sample,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic      [FIELD_W-1:0]  out_total_field_nt,
  output logic      [FIELD_W-1:0]  out_anomaly_nt
);

  localparam int SQ_W = 2 * SAMPLE_BITS;

  state_t               state_r, state_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [GAIN_W-1:0]    gain_r;
  logic [WEIGHT_W-1:0]  weight_r;
  logic [PROD_W-1:0]    prod_r;
  logic [FIELD_W-1:0]   field_r;
  logic [FIELD_W-1:0]   total_r;
  logic [FIELD_W-1:0]   anom_out_r;

  logic                 accept;
  logic                 cfg_wr;
  logic                 load_out;
  logic [SQ_W-1:0]      sq_x, sq_y, sq_z;
  logic [SQ_W-1:0]      sum;
  logic                 sqrt_done;
  logic [SAMPLE_BITS-1:0] root;
  logic [FIELD_W-1:0]   field_sat;
  logic                 ema_done;
  logic [FIELD_W-1:0]   ema_anomaly;

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign cfg_wr   = psel && penable && pwrite;
  assign load_out = (state_r == ST_OUT);

  mfma_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_x (
    .clk(clk), .en(accept), .sample(in_x_sample[SAMPLE_BITS-1:0]), .sq(sq_x)
  );
  mfma_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_y (
    .clk(clk), .en(accept), .sample(in_y_sample[SAMPLE_BITS-1:0]), .sq(sq_y)
  );
  mfma_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_z (
    .clk(clk), .en(accept), .sample(in_z_sample[SAMPLE_BITS-1:0]), .sq(sq_z)
  );

  // three squares of at most 2^(2N-2) each never overflow 2N bits
  assign sum = sq_x + sq_y + sq_z;

  mfma_sqrt #(.SAMPLE_BITS(SAMPLE_BITS)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(state_r == ST_SUM), .radicand(sum),
    .done(sqrt_done), .root(root)
  );

  always_comb begin
    if (prod_r[PROD_W-1:FRAC_W+FIELD_W] != '0) begin
      field_sat = FIELD_MAX;
    end else begin
      field_sat = prod_r[FRAC_W+FIELD_W-1:FRAC_W];
    end
  end

  mfma_ema u_ema (
    .clk(clk), .rst_n(rst_n), .start(state_r == ST_SAT), .field(field_sat),
    .weight(weight_r), .done(ema_done), .anomaly(ema_anomaly)
  );

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM:  state_nxt = ST_ROOT;
      ST_ROOT: begin
        if (sqrt_done) begin
          state_nxt = ST_GAIN;
        end
      end
      ST_GAIN: state_nxt = ST_SAT;
      ST_SAT:  state_nxt = ST_EMA;
      ST_EMA: begin
        if (ema_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      gain_r      <= GAIN_RESET;
      weight_r    <= WEIGHT_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        case (paddr[2])
          REG_GAIN:   gain_r   <= pwdata[GAIN_W-1:0];
          REG_WEIGHT: weight_r <= pwdata[WEIGHT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_GAIN) begin
      prod_r <= GAIN_W'(root) * gain_r;
    end
    if (state_r == ST_SAT) begin
      field_r <= field_sat;
    end
    if (load_out && (!out_valid_r || !out_stall)) begin
      total_r    <= field_r;
      anom_out_r <= ema_anomaly;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_GAIN:   prdata = APB_DW'(gain_r);
      REG_WEIGHT: prdata = APB_DW'(weight_r);
      default:    prdata = '0;
    endcase
  end

  assign pready             = 1'b1;
  assign in_stall           = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_total_field_nt = total_r;
  assign out_anomaly_nt     = anom_out_r;

endmodule
`default_nettype wire

@@ rtl/mfma_lane.sv @@
// One axis lane: magnitude of a signed sample and its registered square.
`default_nettype none
module mfma_lane import mfma_pkg::*; #(
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [SAMPLE_BITS-1:0]   sample,
  output logic      [2*SAMPLE_BITS-1:0] sq
);

  logic [SAMPLE_BITS-1:0]   mag;
  logic [2*SAMPLE_BITS-1:0] sq_r;

  always_comb begin
    if (sample[SAMPLE_BITS-1]) begin
      mag = ~sample + SAMPLE_BITS'(1);
    end else begin
      mag = sample;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= mag * mag;
    end
  end

  assign sq = sq_r;

endmodule
`default_nettype wire

@@ rtl/mfma_sqrt.sv @@
// Iterative floor square root, one root bit per cycle.
`default_nettype none
module mfma_sqrt import mfma_pkg::*; #(
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [2*SAMPLE_BITS-1:0] radicand,
  output logic                          done,
  output logic      [SAMPLE_BITS-1:0]   root
);

  localparam int CNT_W = $clog2(SAMPLE_BITS);

  logic                     busy_r;
  logic                     done_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [2*SAMPLE_BITS-1:0] n_r;
  logic [SAMPLE_BITS:0]     rem_r;
  logic [SAMPLE_BITS-1:0]   root_r;

  logic [SAMPLE_BITS+2:0]   rem_sh;
  logic [SAMPLE_BITS+2:0]   trial;
  logic                     fits;

  always_comb begin
    rem_sh = {rem_r, n_r[2*SAMPLE_BITS-1 -: 2]};
    trial  = {1'b0, root_r, 2'b01};
    fits   = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(SAMPLE_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      n_r <= {n_r[2*SAMPLE_BITS-3:0], 2'b00};
      if (fits) begin
        rem_r  <= (SAMPLE_BITS+1)'(rem_sh - trial);
        root_r <= {root_r[SAMPLE_BITS-2:0], 1'b1};
      end else begin
        rem_r  <= (SAMPLE_BITS+1)'(rem_sh);
        root_r <= {root_r[SAMPLE_BITS-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule
`default_nettype wire

@@ rtl/mfma_ema.sv @@
// Running average update with seeding, and absolute deviation of the field.
`default_nettype none
module mfma_ema import mfma_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [FIELD_W-1:0]  field,
  input  wire logic [WEIGHT_W-1:0] weight,
  output logic                     done,
  output logic      [FIELD_W-1:0]  anomaly
);

  logic [3:0]               ph_r;
  logic                     done_r;
  logic [AVG_W-1:0]         avg_r;
  logic [AVG_W-1:0]         a_r;
  logic [AVG_W-1:0]         fq_r;
  logic [AVG_W-1:0]         phi_r;
  logic [2*FRAC_W-1:0]      plo_r;
  logic [AVG_W-1:0]         pf_r;
  logic [AVG_W:0]           s_r;
  logic [AVG_W:0]           c_r;
  logic [FIELD_W-1:0]       anom_r;

  logic [AVG_W-1:0]         fq;
  logic [AVG_W-1:0]         a_seed;
  logic [AVG_W-1:0]         diff;

  always_comb begin
    fq     = {field, {FRAC_W{1'b0}}};
    a_seed = (avg_r == '0) ? fq : avg_r;
    diff   = (fq_r >= avg_r) ? (fq_r - avg_r) : (avg_r - fq_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= '0;
      done_r <= 1'b0;
      avg_r  <= '0;
    end else begin
      ph_r   <= {ph_r[2:0], start};
      done_r <= ph_r[3];
      if (ph_r[2]) begin
        avg_r <= AVG_W'(s_r - c_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a_seed;
      fq_r  <= fq;
      phi_r <= a_seed[AVG_W-1:FRAC_W] * weight;
      plo_r <= a_seed[FRAC_W-1:0] * weight;
      pf_r  <= field * weight;
    end
    if (ph_r[1]) begin
      s_r <= {1'b0, a_r} + {1'b0, pf_r};
      c_r <= {1'b0, phi_r} + (AVG_W+1)'(plo_r[2*FRAC_W-1:FRAC_W])
             + (AVG_W+1)'(plo_r[FRAC_W-1:0] != '0);
    end
    if (ph_r[3]) begin
      anom_r <= diff[AVG_W-1:FRAC_W];
    end
  end

  assign done    = done_r;
  assign anomaly = anom_r;

endmodule
`default_nettype wire

@@ rtl/mfma_checker.sv @@
// Port-level checker for the field magnitude anomaly block, bound to the top level.
`default_nettype none
module mfma_checker import mfma_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [FIELD_W-1:0] out_total_field_nt,
  input wire logic [FIELD_W-1:0] out_anomaly_nt
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second item taken while first still in work");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(out_total_field_nt) && $stable(out_anomaly_nt)))
    else $error("stalled result changed");

endmodule

bind magnetic_field_magnitude_anomaly mfma_checker u_mfma_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_total_field_nt(out_total_field_nt),
  .out_anomaly_nt(out_anomaly_nt)
);
`default_nettype wire

@@ verif/mfma_checker.sv @@
// Checker: mirrors the registers, predicts field and anomaly per reading, compares results.
`timescale 1ns / 100ps
module mfma_scoreboard import mfma_pkg::*; #(
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [APB_AW-1:0]  paddr,
  input  wire logic [APB_DW-1:0]  pwdata,
  input  wire logic               pready,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic [23:0]        in_x_sample,
  input  wire logic [23:0]        in_y_sample,
  input  wire logic [23:0]        in_z_sample,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic [FIELD_W-1:0] out_total_field_nt,
  input  wire logic [FIELD_W-1:0] out_anomaly_nt,
  output int                      errors,
  output int                      pending,
  output int                      checked
);

  localparam logic [APB_AW-1:0] GAIN_ADDR   = {REG_GAIN, 2'b00};
  localparam logic [APB_AW-1:0] WEIGHT_ADDR = {REG_WEIGHT, 2'b00};
  localparam logic [63:0]       AVG_MASK    = (64'd1 << AVG_W) - 64'd1;

  typedef struct packed {
    logic [FIELD_W-1:0] mag_nt;
    logic [FIELD_W-1:0] anomaly;
  } field_result_t;

  field_result_t       expected_q[$];
  logic [GAIN_W-1:0]   gain_q16;
  logic [WEIGHT_W-1:0] weight_q16;
  logic [63:0]         avg_q16;
  int                  fail_count;
  int                  result_count;

  function automatic logic [63:0] sample_mag(input logic [23:0] raw);
    logic [SAMPLE_BITS-1:0] v;
    logic [SAMPLE_BITS-1:0] neg;
    v   = raw[SAMPLE_BITS-1:0];
    neg = ~v + 1'b1;
    if (v[SAMPLE_BITS-1]) return 64'(neg);
    return 64'(v);
  endfunction

  function automatic logic [63:0] floor_root(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] root;
    logic [63:0] b;
    n    = n_in;
    root = '0;
    b    = 64'h4000_0000_0000_0000;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n    = n - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic field_result_t predict_reading(input logic [23:0] x, input logic [23:0] y,
                                                    input logic [23:0] z);
    logic [63:0] ax, ay, az, root, field, fq, w, diff, anomaly;
    field_result_t r;
    ax    = sample_mag(x);
    ay    = sample_mag(y);
    az    = sample_mag(z);
    root  = floor_root(ax * ax + ay * ay + az * az);
    field = (root * 64'(gain_q16)) >> FRAC_W;
    if (field > 64'(FIELD_MAX)) field = 64'(FIELD_MAX);
    fq = field << FRAC_W;
    w  = 64'(weight_q16);
    if (avg_q16 == 0) avg_q16 = fq;
    avg_q16 = ((avg_q16 * (64'd65536 - w) + fq * w) >> FRAC_W) & AVG_MASK;
    diff    = (fq >= avg_q16) ? fq - avg_q16 : avg_q16 - fq;
    anomaly = diff >> FRAC_W;
    if (anomaly > 64'(FIELD_MAX)) anomaly = 64'(FIELD_MAX);
    r.mag_nt  = field[FIELD_W-1:0];
    r.anomaly = anomaly[FIELD_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    field_result_t want;
    if (!rst_n) begin
      gain_q16     = GAIN_RESET;
      weight_q16   = WEIGHT_RESET;
      avg_q16      = '0;
      fail_count   = 0;
      result_count = 0;
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result with no reading pending: total_field_nt %0d anomaly_nt %0d",
                 out_total_field_nt, out_anomaly_nt);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          result_count++;
          if (out_total_field_nt !== want.mag_nt) begin
            $error("total_field_nt: expected %0d, got %0d", want.mag_nt,
                   out_total_field_nt);
            fail_count++;
          end
          if (out_anomaly_nt !== want.anomaly) begin
            $error("anomaly_nt: expected %0d, got %0d", want.anomaly, out_anomaly_nt);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_q.push_back(predict_reading(in_x_sample, in_y_sample, in_z_sample));
      if (psel && penable && pwrite && pready) begin
        if (paddr == GAIN_ADDR) gain_q16 = pwdata[GAIN_W-1:0];
        else if (paddr == WEIGHT_ADDR) weight_q16 = pwdata[WEIGHT_W-1:0];
      end
    end
    errors  <= fail_count;
    pending <= expected_q.size();
    checked <= result_count;
  end

endmodule

@@ verif/testbench.sv @@
// Testbench top: clock, reset, register settings, reading stimulus and verdict.
`timescale 1ns / 100ps
module testbench;
  import mfma_pkg::*;

  localparam logic [APB_AW-1:0] GAIN_ADDR       = {REG_GAIN, 2'b00};
  localparam logic [APB_AW-1:0] WEIGHT_ADDR     = {REG_WEIGHT, 2'b00};
  localparam int                NUM_PHASES      = 8;
  localparam int                ITEMS_PER_PHASE = 185;
  localparam int                HOLD_CYCLES     = 600;
  localparam int                HOLD_AT_ITEM    = 300;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                psel, penable, pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                in_valid, in_stall;
  logic [23:0]         in_x_sample, in_y_sample, in_z_sample;
  logic                out_valid, out_stall;
  logic [FIELD_W-1:0]  out_total_field_nt, out_anomaly_nt;

  int errors, pending, checked;
  int sent_count  = 0;
  bit idle_enable  = 1'b1;
  bit stall_enable = 1'b1;

  always #5 clk = ~clk;

  magnetic_field_magnitude_anomaly uut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_x_sample(in_x_sample), .in_y_sample(in_y_sample), .in_z_sample(in_z_sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_total_field_nt(out_total_field_nt), .out_anomaly_nt(out_anomaly_nt)
  );

  mfma_scoreboard field_check (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_x_sample(in_x_sample), .in_y_sample(in_y_sample), .in_z_sample(in_z_sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_total_field_nt(out_total_field_nt), .out_anomaly_nt(out_anomaly_nt),
    .errors(errors), .pending(pending), .checked(checked)
  );

  function automatic int gap_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 4);
    if (pick < 98) return $urandom_range(5, 20);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [23:0] rand_axis();
    int unsigned pick;
    logic [23:0] mag;
    pick = $urandom_range(0, 99);
    if (pick < 35) return 24'($urandom);
    if (pick < 85) begin
      mag = (pick < 70) ? 24'($urandom_range(0, 60000)) : 24'($urandom_range(0, 15));
      if ($urandom_range(0, 1)) mag = -mag;
      return mag;
    end
    case ($urandom_range(0, 4))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return 24'h000000;
      3: return 24'h000001;
      default: return 24'hFFFFFF;
    endcase
  endfunction

  task automatic send_reading(input logic [23:0] x, input logic [23:0] y,
                              input logic [23:0] z);
    int n;
    n = idle_enable ? gap_len() : 0;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_x_sample <= x;
    in_y_sample <= y;
    in_z_sample <= z;
    do @(posedge clk); while (in_stall);
    sent_count++;
  endtask

  task automatic reg_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int n;
    bit hold_done;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && sent_count >= HOLD_AT_ITEM) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rst_n && stall_enable && $urandom_range(0, 99) < 25) begin
        n = 1 + gap_len();
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    logic [APB_DW-1:0] gain_word;
    logic [APB_DW-1:0] weight_word;
    rst_n       = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid    = 1'b0;
    in_x_sample = '0;
    in_y_sample = '0;
    in_z_sample = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, unseeded average first
    send_reading(24'h000000, 24'h000000, 24'h000000);
    send_reading(24'h000001, 24'h000000, 24'h000000);
    send_reading(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    send_reading(24'h800000, 24'h800000, 24'h800000);
    send_reading(24'h800000, 24'h000000, 24'h000000);
    send_reading(24'h000000, 24'h800000, 24'h000000);
    send_reading(24'h000000, 24'h000000, 24'h800000);
    send_reading(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_reading(24'h000000, 24'h000000, 24'h000000);
    send_reading(24'h000003, 24'h000004, 24'h000000);
    send_reading(24'hFFFFFD, 24'hFFFFFC, 24'h000000);
    send_reading(24'd20000, -24'd5000, 24'd40000);
    send_reading(24'h7FFFFF, 24'h800000, 24'h000001);
    send_reading(24'h555555, 24'hAAAAAA, 24'h0F0F0F);
    send_reading(24'hAAAAAA, 24'h555555, 24'hF0F0F0);
    send_reading(24'h000000, 24'h000000, 24'h000000);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      gain_word   = 32'(GAIN_RESET);
      weight_word = 32'(WEIGHT_RESET);
      case (p)
        0: begin
          gain_word   = 32'h00FF_FFFF;
          weight_word = 32'd1;
        end
        1: begin
          gain_word   = 32'd1;
          weight_word = 32'd32768;
        end
        2: begin
          gain_word   = $urandom_range(1, 24'hFFFFFF);
          weight_word = $urandom_range(1, 32768);
        end
        3: weight_word = 32'd0;
        4: begin
          gain_word   = 32'd0;
          weight_word = $urandom_range(1, 65535);
        end
        5: begin
          gain_word   = $urandom_range(1, 24'hFFFFFF);
          weight_word = 32'h0000_FFFF;
        end
        6: begin
          gain_word   = {8'hA5, 24'($urandom)};
          weight_word = {16'h5A3C, 16'($urandom_range(1, 32768))};
        end
        default: ;
      endcase
      reg_write(GAIN_ADDR, gain_word);
      reg_write(WEIGHT_ADDR, weight_word);
      idle_enable  = (p % 3) != 2;
      stall_enable = (p % 4) != 1;
      repeat (ITEMS_PER_PHASE) send_reading(rand_axis(), rand_axis(), rand_axis());
    end

    wait_idle();
    repeat (50) @(posedge clk);
    $display("Checked %0d results from %0d readings over %0d register settings",
             checked, sent_count, NUM_PHASES + 1);
    $display("Covered extreme gains and weights, masked writes and a long output hold-off");
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
